/* hdl/depth_range_normalize_core_macros.svh */
// Assertion macros for the depth range normalize core.
// Used by RTL files that carry concurrent checks; no other dependencies.
`ifndef DEPTH_RANGE_NORMALIZE_CORE_MACROS_SVH
`define DEPTH_RANGE_NORMALIZE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define DRN_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define DRN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define DRN_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define DRN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hdl/drn_pkg.sv */
// Package for the depth range normalize core: widths, op codes, FSM and
// status types. No dependencies.
`default_nettype none

package drn_pkg;

   localparam int DEPTH_FRAC_BITS = 24;
   localparam int DEPTH_WIDTH     = 25;
   localparam int OP_WIDTH        = 2;
   localparam int GRAY_WIDTH      = 8;

   // 255 * num needs eight more bits than a depth
   localparam int PROD_WIDTH      = DEPTH_WIDTH + GRAY_WIDTH + 1;
   // one extra step detects quotients beyond the gray range
   localparam int DIV_STEPS       = GRAY_WIDTH + 1;
   localparam int STEP_CNT_WIDTH  = $clog2(DIV_STEPS + 1);

   localparam logic [DEPTH_WIDTH-1:0] DEPTH_ONE =
      DEPTH_WIDTH'(64'd1 << DEPTH_FRAC_BITS);
   localparam logic [GRAY_WIDTH-1:0]  GRAY_TOP  = {GRAY_WIDTH{1'b1}};

   localparam logic [OP_WIDTH-1:0] OP_CLEAR   = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_MEASURE = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_CONVERT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic clear;
      logic measure;
   } range_upd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

/* hdl/drn_req_if.sv */
// Request channel of the depth range normalize core: op and depth sample.
// Depends on drn_pkg.
`default_nettype none

interface drn_req_if;
   logic                             valid;
   logic                             ready;
   logic [drn_pkg::OP_WIDTH-1:0]     op;
   logic [drn_pkg::DEPTH_WIDTH-1:0]  depth;

   modport source (output valid, output op, output depth, input ready);
   modport sink   (input valid, input op, input depth, output ready);
endinterface

`default_nettype wire

/* hdl/drn_rsp_if.sv */
// Response channel of the depth range normalize core: gray level and flat flag.
// Depends on drn_pkg.
`default_nettype none

interface drn_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [drn_pkg::GRAY_WIDTH-1:0]  gray;
   logic                            flat;

   modport source (output valid, output gray, output flat, input ready);
   modport sink   (input valid, input gray, input flat, output ready);
endinterface

`default_nettype wire

/* hdl/drn_range.sv */
// Running depth minimum and maximum of the depth range normalize core.
// Depends on drn_pkg.
`default_nettype none

module drn_range (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire drn_pkg::range_upd_type           upd,
   input  wire logic [drn_pkg::DEPTH_WIDTH-1:0]  depth,
   output logic      [drn_pkg::DEPTH_WIDTH-1:0]  range_min,
   output logic      [drn_pkg::DEPTH_WIDTH-1:0]  range_max
);

   logic [drn_pkg::DEPTH_WIDTH-1:0] min_ff, min_in;
   logic [drn_pkg::DEPTH_WIDTH-1:0] max_ff, max_in;

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (upd.clear) begin
         min_in = drn_pkg::DEPTH_ONE;
         max_in = '0;
      end else if (upd.measure) begin
         if (depth < min_ff) min_in = depth;
         if (depth > max_ff) max_in = depth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= drn_pkg::DEPTH_ONE;
         max_ff <= '0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   assign range_min = min_ff;
   assign range_max = max_ff;

endmodule

`default_nettype wire

/* hdl/drn_div.sv */
// Restoring divider, one quotient bit per cycle, with overflow bit on top.
// Depends on drn_pkg.
`default_nettype none

module drn_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [drn_pkg::PROD_WIDTH-1:0]   dividend,
   input  wire logic [drn_pkg::DEPTH_WIDTH-1:0]  divisor,
   output drn_pkg::div_stat_type                 stat,
   output logic      [drn_pkg::GRAY_WIDTH-1:0]   quot
);

   localparam int PW = drn_pkg::PROD_WIDTH;
   localparam int QW = drn_pkg::DIV_STEPS;
   localparam int CW = drn_pkg::STEP_CNT_WIDTH;

   logic [PW-1:0] rem_ff, rem_in;
   logic [PW-1:0] dsr_ff, dsr_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          ge;

   // the shared compare-subtract
   assign ge = (rem_ff >= dsr_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsr_in  = PW'(divisor) << drn_pkg::GRAY_WIDTH;
         quo_in  = '0;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) rem_in = rem_ff - dsr_ff;
         dsr_in = dsr_ff >> 1;
         quo_in = {quo_ff[QW-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   // clamp quotients past the gray range
   assign quot      = quo_ff[QW-1] ? drn_pkg::GRAY_TOP : quo_ff[QW-2:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

/* hdl/depth_range_normalize_core.sv */
// Depth range normalize core: min-max normalization of depth to gray.
// Clear and measure transfers complete at the request transfer; a convert transfer
// runs to a valid response through setup, 9 divider steps, done and result, or
// through setup and result for an empty range; the next request is taken once the
// response transfer completes. Rate is set by the shared restoring divider.
// Synchronous active-high reset: range 1.0/0, FSM idle, no response pending.
`default_nettype none
`include "depth_range_normalize_core_macros.svh"

module depth_range_normalize_core (
   input  wire logic  clock,
   input  wire logic  reset,
   drn_req_if.sink    req,
   drn_rsp_if.source  rsp
);

   localparam int DW = drn_pkg::DEPTH_WIDTH;
   localparam int PW = drn_pkg::PROD_WIDTH;
   localparam int GW = drn_pkg::GRAY_WIDTH;

   drn_pkg::state_type      state_ff, state_in;
   drn_pkg::range_upd_type  upd;
   drn_pkg::div_stat_type   div_stat;

   logic [DW-1:0] range_min, range_max;
   logic [DW-1:0] depth_ff, depth_in;
   logic [GW-1:0] gray_ff, gray_in;
   logic          flat_ff, flat_in;
   logic [GW-1:0] quot;

   logic          req_xfer;
   logic          rsp_xfer;
   logic          degenerate;
   logic [DW-1:0] den;
   logic [DW-1:0] num;
   logic [PW-1:0] dividend;
   logic          div_start;

   assign req_xfer = req.valid && req.ready;
   assign rsp_xfer = rsp.valid && rsp.ready;

   // Clear and measure act on the range at the request transfer itself.
   assign upd.clear   = req_xfer && (req.op == drn_pkg::OP_CLEAR);
   assign upd.measure = req_xfer && (req.op == drn_pkg::OP_MEASURE);

   drn_range u_range (
      .clock     (clock),
      .reset     (reset),
      .upd       (upd),
      .depth     (req.depth),
      .range_min (range_min),
      .range_max (range_max)
   );

   // Setup math: an empty range goes straight to the flat result; a sample
   // beyond the maximum gives a zero numerator; 255*num is a shift and subtract.
   assign degenerate = (range_max <= range_min);
   assign den        = range_max - range_min;
   assign num        = (depth_ff >= range_max) ? '0 : (range_max - depth_ff);
   assign dividend   = (PW'(num) << GW) - PW'(num);

   drn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (den),
      .stat     (div_stat),
      .quot     (quot)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         drn_pkg::ST_IDLE: begin
            if (req_xfer && (req.op == drn_pkg::OP_CONVERT)) state_in = drn_pkg::ST_SETUP;
         end
         drn_pkg::ST_SETUP: begin
            state_in = degenerate ? drn_pkg::ST_RESULT : drn_pkg::ST_DIVIDE;
         end
         drn_pkg::ST_DIVIDE: begin
            if (div_stat.done) state_in = drn_pkg::ST_RESULT;
         end
         drn_pkg::ST_RESULT: begin
            if (rsp_xfer) state_in = drn_pkg::ST_IDLE;
         end
         default: state_in = drn_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath loads.
   always_comb begin
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      div_start = 1'b0;
      depth_in  = depth_ff;
      gray_in   = gray_ff;
      flat_in   = flat_ff;
      case (state_ff)
         drn_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            depth_in  = req.depth;
         end
         drn_pkg::ST_SETUP: begin
            // hold the flat answer for an empty range, else launch the divide
            if (degenerate) begin
               gray_in = drn_pkg::GRAY_TOP;
               flat_in = 1'b1;
            end else begin
               div_start = 1'b1;
            end
         end
         drn_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               gray_in = quot;
               flat_in = 1'b0;
            end
         end
         drn_pkg::ST_RESULT: begin
            rsp.valid = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      depth_ff <= depth_in;
      gray_ff  <= gray_in;
      flat_ff  <= flat_in;
   end

   assign rsp.gray = gray_ff;
   assign rsp.flat = flat_ff;

   // Checks.
   `DRN_ASSERT_IMPLIES(a_ready_no_rsp, clock, reset, req.ready, !rsp.valid)
   `DRN_ASSERT_IMPLIES(a_flat_is_top, clock, reset, rsp.valid && rsp.flat, rsp.gray == drn_pkg::GRAY_TOP)
   `DRN_ASSERT_IMPLIES(a_done_in_divide, clock, reset, div_stat.done, state_ff == drn_pkg::ST_DIVIDE)
   `DRN_ASSERT_NEXT(a_measure_max, clock, reset, upd.measure, range_max >= $past(req.depth))

endmodule

`default_nettype wire
